// File: rtl/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// Holds the classified-pixel record and the reciprocal table used by the back end.
// Depends on nothing.
package rgbhsl_pkg;

  // Degrees in one hue sector, and sector bases.
  localparam logic [5:0] SectorDeg = 6'd60;
  localparam logic [8:0] Hue0      = 9'd0;
  localparam logic [8:0] Hue60     = 9'd60;
  localparam logic [8:0] Hue180    = 9'd180;
  localparam logic [8:0] Hue300    = 9'd300;
  localparam logic [8:0] HueFull   = 9'd360;

  localparam logic [6:0] Percent   = 7'd100;

  // Lightness is floor(10*sum/51), done as a multiply by ceil(2^20/51).
  localparam logic [3:0]  LightScale = 4'd10;
  localparam logic [14:0] LightRecip = 15'd20561;
  localparam int unsigned LightShift = 20;

  // Reciprocal table: floor(2^16/d), with a 16-bit fraction.
  localparam int unsigned RecipShift = 16;
  typedef logic [16:0] recip_tab_t [256];

  // Pixel after classification: everything the back end needs.
  typedef struct packed {
    logic       zero;    // grey or black: hue and saturation are zero
    logic [7:0] spread;  // max - min, divisor of the hue fraction
    logic [7:0] den;     // divisor of the saturation
    logic [8:0] sum;     // max + min
    logic [7:0] hy;      // channel distance that sets the fraction in the sector
    logic [8:0] base;    // sector base in degrees
    logic       neg;     // fraction is taken away from the base
  } cls_t;

  // Built once at elaboration by restoring long division.
  function automatic recip_tab_t recip_table();
    recip_tab_t  tab;
    logic [8:0]  rem;
    logic [16:0] quo;
    logic [16:0] dividend;
    dividend = 17'h10000;
    for (int d = 0; d < 256; d++) begin
      rem = '0;
      quo = '0;
      for (int i = 16; i >= 0; i--) begin
        rem = {rem[7:0], dividend[i]};
        if (d != 0 && rem >= 9'(d)) begin
          rem    = rem - 9'(d);
          quo[i] = 1'b1;
        end
      end
      tab[d] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RecipTab = recip_table();

endpackage

// File: rtl/rgb_to_hsl_top.sv
// Top level of the RGB to HSL converter.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_fifo and rgbhsl_back.
//
// Usage: a pixel beat (red_i, green_i, blue_i) is taken at a rising edge with
// push high and full low. Results leave as a queue: while empty is low the
// oldest result sits on hue_o, saturation_o and lightness_o, and it is taken
// at a rising edge with pop high. Results come out in the order of the pixels.
// The front end finds max, min and the hue sector in the cycle of the push
// and writes the classified pixel into a queue of QueueDepth entries. The
// back end reads that queue into a three-stage pipeline: reciprocal-table
// multiplies, remainder multiplies, then a one-step correction into the
// output register. Each result shows once its pixel has left the third stage.
// Throughput is one pixel per clock while pop is high, set by the single pass
// through each back-end stage; push and pop may both fire in every cycle.
// When the receiver stalls, the back-end pipeline holds as a whole, the
// queue absorbs the pixels in flight, and full rises once it is used up.
// Reset empties the queue and the pipeline: full and empty read low and
// high right after it. No memory needs clearing.
module rgb_to_hsl_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       empty,
  input  logic       pop,
  output logic [8:0] hue_o,
  output logic [6:0] saturation_o,
  output logic [6:0] lightness_o
);

  rgbhsl_pkg::cls_t front_cls;
  rgbhsl_pkg::cls_t queue_cls;
  logic             queue_empty;
  logic             back_ready;

  rgbhsl_front u_front (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .cls_o   (front_cls)
  );

  rgbhsl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_cls),
    .full_o  (full),
    .rd_i    (back_ready),
    .rdata_o (queue_cls),
    .empty_o (queue_empty)
  );

  rgbhsl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (!queue_empty),
    .cls_i        (queue_cls),
    .ready_o      (back_ready),
    .empty_o      (empty),
    .pop_i        (pop),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .lightness_o  (lightness_o)
  );

endmodule

// File: rtl/rgbhsl_front.sv
// Front end of the RGB to HSL converter: finds max and min and the hue sector.
// Depends on rgbhsl_pkg.
module rgbhsl_front (
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output rgbhsl_pkg::cls_t  cls_o
);

  logic [7:0] mx;
  logic [7:0] mn;
  logic [8:0] sum;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mx = (mx > blue_i) ? mx : blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    mn = (mn < blue_i) ? mn : blue_i;
    sum = {1'b0, mx} + {1'b0, mn};

    cls_o.sum    = sum;
    cls_o.spread = mx - mn;
    cls_o.zero   = (mx == mn);
    cls_o.den    = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);

    // Tie order: red wins over green, green over blue.
    cls_o.neg = 1'b0;
    if (red_i == mx) begin
      if (green_i == mn) begin
        cls_o.base = rgbhsl_pkg::Hue300;
        cls_o.hy   = mx - blue_i;
      end else begin
        cls_o.base = rgbhsl_pkg::Hue0;
        cls_o.hy   = green_i - mn;
      end
    end else if (green_i == mx) begin
      if (blue_i == mn) begin
        cls_o.base = rgbhsl_pkg::Hue60;
        cls_o.hy   = mx - red_i;
      end else begin
        cls_o.base = rgbhsl_pkg::Hue180;
        cls_o.hy   = mx - blue_i;
        cls_o.neg  = 1'b1;
      end
    end else begin
      if (red_i == mn) begin
        cls_o.base = rgbhsl_pkg::Hue180;
        cls_o.hy   = mx - green_i;
      end else begin
        cls_o.base = rgbhsl_pkg::Hue300;
        cls_o.hy   = mx - red_i;
        cls_o.neg  = 1'b1;
      end
    end
  end

endmodule

// File: rtl/rgbhsl_fifo.sv
// Short queue of classified pixels between the front end and the back end.
// Depends on rgbhsl_pkg.
module rgbhsl_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  rgbhsl_pkg::cls_t wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output rgbhsl_pkg::cls_t rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rgbhsl_pkg::cls_t mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/rgbhsl_back.sv
// Back end of the RGB to HSL converter: three-stage divide by reciprocal and
// correction, ending in the output register. Depends on rgbhsl_pkg.
module rgbhsl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rgbhsl_pkg::cls_t cls_i,
  output logic             ready_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [8:0]       hue_o,
  output logic [6:0]       saturation_o,
  output logic [6:0]       lightness_o
);

  logic en;
  logic v1_q, v2_q, v3_q;

  // Stage 1: products with the reciprocals.
  logic [13:0] hnum;
  logic [14:0] snum;
  logic [12:0] lnum;
  logic [30:0] hprod;
  logic [31:0] sprod;
  logic [26:0] lprod;

  logic [13:0] hnum1_q;
  logic [14:0] snum1_q;
  logic [7:0]  hq1_q, sq1_q;
  logic [7:0]  spread1_q, den1_q;
  logic [8:0]  base1_q;
  logic        neg1_q, zero1_q;
  logic [6:0]  light1_q;

  // Stage 2: remainders of the estimates.
  logic [15:0] hmul, smul;
  logic [7:0]  hq2_q, sq2_q;
  logic [8:0]  hr2_q, sr2_q;
  logic [7:0]  spread2_q, den2_q;
  logic [8:0]  base2_q;
  logic        neg2_q, zero2_q;
  logic [6:0]  light2_q;

  // Stage 3: correction and hue assembly.
  logic        hcarry, scarry;
  logic [8:0]  hrem;
  logic [8:0]  hq;
  logic [8:0]  hraw;
  logic [8:0]  hue_d;
  logic [6:0]  sat_d;
  logic [8:0]  hue3_q;
  logic [6:0]  sat3_q, light3_q;

  assign en      = !v3_q || pop_i;
  assign ready_o = en;
  assign empty_o = !v3_q;

  assign hnum  = 14'(cls_i.hy) * 14'(rgbhsl_pkg::SectorDeg);
  assign snum  = 15'(cls_i.spread) * 15'(rgbhsl_pkg::Percent);
  assign lnum  = 13'(cls_i.sum) * 13'(rgbhsl_pkg::LightScale);
  assign hprod = 31'(hnum) * 31'(rgbhsl_pkg::RecipTab[cls_i.spread]);
  assign sprod = 32'(snum) * 32'(rgbhsl_pkg::RecipTab[cls_i.den]);
  assign lprod = 27'(lnum) * 27'(rgbhsl_pkg::LightRecip);

  assign hmul = 16'(hq1_q) * 16'(spread1_q);
  assign smul = 16'(sq1_q) * 16'(den1_q);

  always_comb begin
    hcarry = (hr2_q >= {1'b0, spread2_q});
    scarry = (sr2_q >= {1'b0, den2_q});
    hrem   = hcarry ? (hr2_q - {1'b0, spread2_q}) : hr2_q;
    hq     = {1'b0, hq2_q} + 9'(hcarry);
    if (neg2_q) begin
      // Floor of base minus a fraction: take the ceiling of the fraction.
      hraw = base2_q - hq - 9'(hrem != '0);
    end else begin
      hraw = base2_q + hq;
    end
    hue_d = (hraw >= rgbhsl_pkg::HueFull) ? (hraw - rgbhsl_pkg::HueFull) : hraw;
    sat_d = 7'(sq2_q) + 7'(scarry);
    if (zero2_q) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hnum1_q   <= hnum;
      snum1_q   <= snum;
      hq1_q     <= hprod[rgbhsl_pkg::RecipShift +: 8];
      sq1_q     <= sprod[rgbhsl_pkg::RecipShift +: 8];
      spread1_q <= cls_i.spread;
      den1_q    <= cls_i.den;
      base1_q   <= cls_i.base;
      neg1_q    <= cls_i.neg;
      zero1_q   <= cls_i.zero;
      light1_q  <= lprod[rgbhsl_pkg::LightShift +: 7];

      hq2_q     <= hq1_q;
      sq2_q     <= sq1_q;
      hr2_q     <= 9'(16'(hnum1_q) - hmul);
      sr2_q     <= 9'(16'(snum1_q) - smul);
      spread2_q <= spread1_q;
      den2_q    <= den1_q;
      base2_q   <= base1_q;
      neg2_q    <= neg1_q;
      zero2_q   <= zero1_q;
      light2_q  <= light1_q;

      hue3_q    <= hue_d;
      sat3_q    <= sat_d;
      light3_q  <= light2_q;
    end
  end

  assign hue_o        = hue3_q;
  assign saturation_o = sat3_q;
  assign lightness_o  = light3_q;

endmodule

// File: rtl/rgb_to_hsl_checker.sv
// Port-level checks for the RGB to HSL converter, bound to the top level.
// Depends on rgb_to_hsl_top.
module rgb_to_hsl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [8:0] hue_o,
  input logic [6:0] saturation_o,
  input logic [6:0] lightness_o
);

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> hue_o < 9'd360)
    else $error("hue out of range");

  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> saturation_o <= 7'd100)
    else $error("saturation out of range");

  a_light_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> lightness_o <= 7'd100)
    else $error("lightness out of range");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hue_o) && $stable(saturation_o)
                          && $stable(lightness_o)))
    else $error("waiting result changed");

endmodule

bind rgb_to_hsl_top rgb_to_hsl_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .lightness_o  (lightness_o)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsl_top: predicts hue, saturation and lightness per pixel.
// Depends on rgb_to_hsl_top and the rtl sources it pulls in (rgbhsl_pkg and the sub-blocks).
module tb_top;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] lightness;
  } hsl_t;

  typedef enum logic [1:0] {
    RxAlways,
    RxRandom,
    RxLongStall
  } rx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] red_i = 8'd0;
  logic [7:0] green_i = 8'd0;
  logic [7:0] blue_i = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [8:0] hue_o;
  logic [6:0] saturation_o;
  logic [6:0] lightness_o;

  // Expected results, oldest first, in the order the pixels were accepted.
  hsl_t     hsl_expected[$];
  rx_mode_e rx_mode = RxAlways;
  bit       tx_bursty = 1'b0;
  int       burst_left = 1;
  int       rx_hold = 0;
  int       mismatches = 0;
  int       pixels_sent = 0;
  int       results_checked = 0;
  int       greys_sent = 0;
  int       pauses_taken = 0;

  rgb_to_hsl_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .empty       (empty),
    .pop         (pop),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .lightness_o (lightness_o)
  );

  always #5 clk_i = ~clk_i;

  // Integer HSL conversion with truncating division. The hue sector is chosen
  // with red winning ties over green and green over blue, and inside each
  // sector the branch depends on whether the following channel is the minimum.
  function automatic hsl_t predict_hsl(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned rr, gg, bb, mx, mn, sum, spread, den, num, h;
    hsl_t res;
    rr = r;
    gg = g;
    bb = b;
    mx = rr;
    if (gg > mx) mx = gg;
    if (bb > mx) mx = bb;
    mn = rr;
    if (gg < mn) mn = gg;
    if (bb < mn) mn = bb;
    sum = mx + mn;
    spread = mx - mn;
    res.hue = '0;
    res.saturation = '0;
    res.lightness = 7'((100 * sum) / 510);
    // Black and grey pixels keep hue and saturation at zero.
    if (sum != 0 && spread != 0) begin
      den = (sum <= 255) ? sum : (510 - sum);
      res.saturation = 7'((100 * spread) / den);
      if (rr == mx) begin
        if (gg == mn) num = 300 * spread + 60 * (mx - bb);
        else num = 60 * (gg - mn);
      end else if (gg == mx) begin
        if (bb == mn) num = 60 * spread + 60 * (mx - rr);
        else num = 180 * spread - 60 * (mx - bb);
      end else begin
        if (rr == mn) num = 180 * spread + 60 * (mx - gg);
        else num = 300 * spread - 60 * (mx - rr);
      end
      h = num / spread;
      // Pure red lands on a full turn and wraps back to zero degrees.
      if (h >= 360) h = h - 360;
      res.hue = 9'(h);
    end
    return res;
  endfunction

  // Offers one pixel beat and holds it until the block takes it. Push stays
  // high into the next call unless the burst ends, so back-to-back beats
  // never see push dropped and raised in the same step.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    push    <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    hsl_expected.push_back(predict_hsl(r, g, b));
    pixels_sent++;
    if (r == g && g == b) greys_sent++;
    if (tx_bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // Stops sending and waits until every pixel in flight has come back.
  // At least one edge passes, so a following push never lands in this step.
  task automatic wait_for_drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (hsl_expected.size() != 0) @(posedge clk_i);
  endtask

  // Mostly uniform pixels, with a share of greys, ties, saturated corners and
  // near-grey colors so the branchy parts of the hue math are hit often.
  task automatic random_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    logic [7:0] base;
    int         kind;
    kind = $urandom_range(0, 9);
    base = 8'($urandom);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case (kind)
      6: begin
        r = base;
        g = base;
        b = base;
      end
      7: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: r = b;
        endcase
      end
      8: begin
        r = $urandom_range(0, 1) ? 8'hff : 8'h00;
        g = $urandom_range(0, 1) ? 8'hff : 8'h00;
        b = $urandom_range(0, 1) ? 8'h1 : 8'hfe;
      end
      9: begin
        r = base;
        g = base ^ 8'($urandom_range(0, 1));
        b = base ^ 8'($urandom_range(0, 3));
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_random(input int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Extremes of the channels, each sector branch, the saturation divisor
  // switch around sum 255, and the wrap of pure red back to zero degrees.
  task automatic test_corners();
    tx_bursty = 1'b0;
    rx_mode = RxAlways;
    send_pixel(8'd0, 8'd0, 8'd0);       // black
    send_pixel(8'd255, 8'd255, 8'd255); // white
    send_pixel(8'd128, 8'd128, 8'd128); // mid grey
    send_pixel(8'd1, 8'd1, 8'd1);       // darkest grey
    send_pixel(8'd255, 8'd0, 8'd0);     // pure red wraps to zero
    send_pixel(8'd0, 8'd255, 8'd0);     // pure green
    send_pixel(8'd0, 8'd0, 8'd255);     // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);   // yellow, red and green tie
    send_pixel(8'd0, 8'd255, 8'd255);   // cyan, green and blue tie
    send_pixel(8'd255, 8'd0, 8'd255);   // magenta, red and blue tie
    send_pixel(8'd255, 8'd0, 8'd1);     // just short of a full turn
    send_pixel(8'd200, 8'd10, 8'd60);   // red max, green min
    send_pixel(8'd200, 8'd90, 8'd10);   // red max, blue min
    send_pixel(8'd70, 8'd220, 8'd5);    // green max, blue min
    send_pixel(8'd3, 8'd220, 8'd100);   // green max, red min
    send_pixel(8'd2, 8'd40, 8'd250);    // blue max, red min
    send_pixel(8'd90, 8'd4, 8'd250);    // blue max, green min
    send_pixel(8'd255, 8'd1, 8'd1);     // sum 256, divisor switches side
    send_pixel(8'd128, 8'd127, 8'd127); // sum 255, spread 1
    send_pixel(8'd100, 8'd101, 8'd100); // smallest spread in the dark half
    send_pixel(8'd255, 8'd254, 8'd255); // smallest spread at the top
    send_pixel(8'd1, 8'd0, 8'd0);       // dimmest color
    wait_for_drain();
  endtask

  // Both sides at full rate: one beat in and one out on every clock.
  task automatic test_streaming();
    tx_bursty = 1'b0;
    rx_mode = RxAlways;
    send_random(400);
    wait_for_drain();
  endtask

  // Bursty sender against a receiver that drops pop at random.
  task automatic test_bursty();
    tx_bursty = 1'b1;
    rx_mode = RxRandom;
    send_random(600);
    wait_for_drain();
  endtask

  // Long receiver stalls so the queue fills and full holds the sender off.
  task automatic test_backpressure();
    tx_bursty = 1'b0;
    rx_mode = RxLongStall;
    send_random(250);
    tx_bursty = 1'b1;
    send_random(250);
    wait_for_drain();
  endtask

  // The sender repeatedly goes quiet until all results are back, then resumes.
  task automatic test_pause();
    tx_bursty = 1'b1;
    rx_mode = RxRandom;
    for (int chunk = 0; chunk < 7; chunk++) begin
      send_random(50);
      wait_for_drain();
      pauses_taken++;
    end
  endtask

  // Result side: compare each popped beat with the oldest prediction, then
  // choose the next value of pop according to the current stall pattern.
  always @(posedge clk_i) begin : result_check
    hsl_t want;
    if (pop && !empty) begin
      if (hsl_expected.size() == 0) begin
        $error("result beat with no pixel pending: hue %0d saturation %0d lightness %0d",
               hue_o, saturation_o, lightness_o);
        mismatches++;
      end else begin
        want = hsl_expected.pop_front();
        results_checked++;
        if (hue_o !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, hue_o);
          mismatches++;
        end
        if (saturation_o !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation, saturation_o);
          mismatches++;
        end
        if (lightness_o !== want.lightness) begin
          $error("lightness: expected %0d, got %0d", want.lightness, lightness_o);
          mismatches++;
        end
      end
    end
    case (rx_mode)
      RxAlways: pop <= 1'b1;
      RxRandom: pop <= ($urandom_range(0, 3) != 0);
      default: begin
        // Alternate long stalls with short pop windows.
        if (rx_hold > 0) begin
          rx_hold = rx_hold - 1;
        end else begin
          pop <= ~pop;
          rx_hold = pop ? $urandom_range(4, 20) : $urandom_range(1, 8);
        end
      end
    endcase
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("rgb_to_hsl_top regression: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 12);

    test_corners();
    test_streaming();
    test_bursty();
    test_backpressure();
    test_pause();

    // The block shows a result once its push has passed the queue and pipeline;
    // give it a margin so any stray extra beat is still caught by the checker.
    wait_for_drain();
    repeat (12) @(posedge clk_i);

    $display("Checked %0d results for %0d pixels, %0d of them grey.",
             results_checked, pixels_sent, greys_sent);
    $display("Ran full-rate, bursty, long-stall and %0d drain-pause phases.", pauses_taken);
    if (mismatches == 0 && hsl_expected.size() == 0) begin
      $display("rgb_to_hsl_top regression: pass");
    end else begin
      $display("rgb_to_hsl_top regression: fail");
    end
    $finish;
  end

endmodule
